@@ rtl/cfa_pkg.sv @@
package cfa_pkg;

  localparam int TABLE_UNITS = 1024;
  localparam int OWNER_BITS  = 8;

  localparam int ADDR_W     = $clog2(TABLE_UNITS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SIZE_W     = 11;
  localparam int OWNER_IN_W = 8;
  localparam int START_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int POLICY_W   = 2;
  localparam int LEN_W      = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [OWNER_BITS-1:0] owner_t;

  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO   = 2'd2;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_FREE
  } state_t;

endpackage

@@ rtl/cfa_ram.sv @@
module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/contiguous_fit_allocator_unit.sv @@
// Allocate: a scan over every unit plus one step past the end, then request_size fill
// steps when a run fits (no fill when none fits); the result strobes the cycle after
// the last of them. Free: a walk over every unit. Zero-size allocate: result the cycle
// after start. One item at a time, set by the owner-table RAM walk; busy is high
// meanwhile. Reset (rst_n low at a clock edge) clears policy to first fit, then a clearing
// pass over every unit zeroes the owner table with busy high. Results are not stalled.
module contiguous_fit_allocator_unit
  import cfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [OWNER_IN_W-1:0] in_owner_id,
  input  logic [SIZE_W-1:0]     in_request_size,
  // result channel
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [START_W-1:0]    out_start_unit,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [POLICY_W-1:0]   cfg_fit_policy
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  cnt_t                  idx_r, idx_nxt;          // unit under inspection
  len_t                  run_len_r, run_len_nxt;  // length of the open free run
  addr_t                 run_start_r, run_start_nxt;
  logic                  have_r, have_nxt;        // a fitting run was chosen
  len_t                  best_len_r, best_len_nxt;
  addr_t                 best_start_r, best_start_nxt;
  len_t                  fill_r, fill_nxt;        // units written so far
  len_t                  size_r, size_nxt;
  owner_t                owner_r, owner_nxt;
  logic [POLICY_W-1:0]   policy_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [START_W-1:0]    out_start_unit_r, out_start_unit_nxt;

  // owner table port
  logic                  ram_we;
  addr_t                 ram_waddr;
  owner_t                ram_wdata;
  addr_t                 ram_raddr;
  owner_t                ram_rdata;

  logic                  accept;
  logic                  is_free;
  logic                  better;
  logic                  cand_ok;
  logic                  found;
  logic                  scan_last;
  logic                  walk_last;
  logic                  fill_last;

  cfa_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (TABLE_UNITS)
  ) u_owner_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Shared run compare: the read data lines up with idx_r. The step past the
  // last unit reads as occupied so a run reaching the end gets closed.
  // ---------------------------------------------------------------------------
  assign is_free   = (idx_r < CNT_W'(TABLE_UNITS)) && (ram_rdata == '0);
  assign better    = !have_r
                   || ((policy_r == POL_BEST)  && (run_len_r < best_len_r))
                   || ((policy_r == POL_WORST) && (run_len_r > best_len_r));
  assign cand_ok   = !is_free && (run_len_r != '0) && (run_len_r >= size_r) && better;
  assign found     = have_r || cand_ok;
  assign scan_last = (idx_r == CNT_W'(TABLE_UNITS));
  assign walk_last = (idx_r == CNT_W'(TABLE_UNITS - 1));
  assign fill_last = (fill_r == size_r - LEN_W'(1));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_FREE) begin
            state_nxt = S_FREE;
          end else if (in_request_size != '0) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = found ? S_FILL : S_IDLE;
        end
      end
      S_FILL: begin
        if (fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        if (walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and table port
  // ---------------------------------------------------------------------------
  always_comb begin
    idx_nxt            = idx_r;
    run_len_nxt        = run_len_r;
    run_start_nxt      = run_start_r;
    have_nxt           = have_r;
    best_len_nxt       = best_len_r;
    best_start_nxt     = best_start_r;
    fill_nxt           = fill_r;
    size_nxt           = size_r;
    owner_nxt          = owner_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_start_unit_nxt = out_start_unit_r;
    ram_we             = 1'b0;
    ram_waddr          = idx_r[ADDR_W-1:0];
    ram_wdata          = '0;

    case (state_r)
      S_CLEAR: begin
        // zero one unit a cycle
        ram_we  = 1'b1;
        idx_nxt = walk_last ? '0 : idx_r + CNT_W'(1);
      end
      S_IDLE: begin
        // keep unit 0 in flight so a scan starts aligned
        idx_nxt = '0;
        if (accept) begin
          owner_nxt      = OWNER_BITS'(in_owner_id);
          size_nxt       = LEN_W'(in_request_size);
          run_len_nxt    = '0;
          have_nxt       = 1'b0;
          best_len_nxt   = '0;
          best_start_nxt = '0;
          fill_nxt       = '0;
          if ((in_kind == KIND_ALLOC) && (in_request_size == '0)) begin
            out_valid_nxt      = 1'b1;
            out_status_nxt     = STAT_ZERO;
            out_start_unit_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + CNT_W'(1);
        if (is_free) begin
          if (run_len_r == '0) begin
            run_start_nxt = idx_r[ADDR_W-1:0];
          end
          run_len_nxt = run_len_r + LEN_W'(1);
        end else begin
          run_len_nxt = '0;
        end
        if (cand_ok) begin
          have_nxt       = 1'b1;
          best_start_nxt = run_start_r;
          best_len_nxt   = run_len_r;
        end
        if (scan_last && !found) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = STAT_NO_FIT;
          out_start_unit_nxt = '0;
        end
      end
      S_FILL: begin
        // the chosen run is long enough, so the write never wraps
        ram_we    = 1'b1;
        ram_waddr = best_start_r + fill_r[ADDR_W-1:0];
        ram_wdata = owner_r;
        fill_nxt  = fill_r + LEN_W'(1);
        if (fill_last) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = STAT_DONE;
          out_start_unit_nxt = START_W'(best_start_r);
        end
      end
      S_FREE: begin
        idx_nxt = idx_r + CNT_W'(1);
        if (ram_rdata == owner_r) begin
          ram_we = 1'b1;
        end
        if (walk_last) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = STAT_DONE;
          out_start_unit_nxt = '0;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // read one unit ahead so the registered data meets idx_r
  assign ram_raddr = idx_nxt[ADDR_W-1:0];

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      policy_r    <= POL_FIRST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        policy_r <= cfg_fit_policy;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_len_r        <= run_len_nxt;
    run_start_r      <= run_start_nxt;
    have_r           <= have_nxt;
    best_len_r       <= best_len_nxt;
    best_start_r     <= best_start_nxt;
    fill_r           <= fill_nxt;
    size_r           <= size_nxt;
    owner_r          <= owner_nxt;
    out_status_r     <= out_status_nxt;
    out_start_unit_r <= out_start_unit_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_unit = out_start_unit_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result transaction during table clearing");

  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_DONE)) |-> (out_start_unit_r == '0))
    else $error("failed allocate reports a nonzero start unit");

  a_fill_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (have_r && (best_len_r >= size_r) && (fill_r < size_r)))
    else $error("fill runs past the chosen free run");

  a_scan_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_ALLOC) && (in_request_size != '0)) |=> busy)
    else $error("allocate transaction accepted without going busy");

endmodule

@@ tb/contiguous_fit_allocator_unit_tb.sv @@
module contiguous_fit_allocator_unit_tb;
  import cfa_pkg::*;

  // Spare placement code: the block treats it as first fit.
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

  // Script rows with this policy value leave the register alone.
  localparam int KEEP_POLICY = -1;

  localparam int SCRIPT_ROWS   = 24;
  localparam int SOAK_PHASES   = 8;
  localparam int PHASE_ITEMS   = 33;
  // Worst case for one item is a full scan plus a full fill.
  localparam int DRAIN_CYCLES  = 2200;
  // Allow several times the run of about 290 items at their slowest with the longest
  // sender gap, in time units (2 per cycle).
  localparam int RUN_LIMIT     = 6000000;

  typedef struct {
    int                    policy;
    logic                  kind;
    logic [OWNER_IN_W-1:0] owner;
    logic [SIZE_W-1:0]     units;
    bit                    typed;
    logic [STATUS_W-1:0]   status;
    logic [START_W-1:0]    start_unit;
  } script_row_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_unit;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_kind;
  logic [OWNER_IN_W-1:0] in_owner_id;
  logic [SIZE_W-1:0]     in_request_size;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [START_W-1:0]    out_start_unit;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [POLICY_W-1:0]   cfg_fit_policy;

  // Shadow of the block: owner of every unit and the placement rule in force.
  owner_t                unit_owner [TABLE_UNITS];
  logic [POLICY_W-1:0]   model_policy;

  // Outcomes still owed by the block, oldest first.
  outcome_t              pending_outcomes [$];

  // Handshake counters, bumped at the rising edge and watched at the falling edge.
  int unsigned           items_taken;
  int unsigned           policy_writes;
  int unsigned           mismatch_cnt;

  // Typed-in outcome for the transaction currently offered, if the script has one.
  bit                    typed_check;
  logic [STATUS_W-1:0]   typed_status;
  logic [START_W-1:0]    typed_start;

  // Directed script. Typed-in outcomes cover the empty and full table, the zero-size
  // and oversized cases and every free; the fragmented rows lean on the shadow model.
  script_row_t script [SCRIPT_ROWS] = '{
    // zero size on an empty table
    '{KEEP_POLICY, KIND_ALLOC, 8'd1,   11'd0,    1'b1, STAT_ZERO,   10'd0},
    // whole table in one run, then nothing left
    '{KEEP_POLICY, KIND_ALLOC, 8'd1,   11'd1024, 1'b1, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd2,   11'd1,    1'b1, STAT_NO_FIT, 10'd0},
    '{KEEP_POLICY, KIND_FREE,  8'd1,   11'd0,    1'b1, STAT_DONE,   10'd0},
    // leave exactly the last unit free, then take it
    '{KEEP_POLICY, KIND_ALLOC, 8'd255, 11'd1023, 1'b1, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd128, 11'd1,    1'b1, STAT_DONE,   10'd1023},
    // size field is ignored on a free
    '{KEEP_POLICY, KIND_FREE,  8'd255, 11'd1024, 1'b1, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_FREE,  8'd128, 11'd2047, 1'b1, STAT_DONE,   10'd0},
    // carve holes of 8, 16 and the tail
    '{KEEP_POLICY, KIND_ALLOC, 8'd10,  11'd4,    1'b1, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd11,  11'd8,    1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd12,  11'd2,    1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd13,  11'd16,   1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd14,  11'd3,    1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_FREE,  8'd11,  11'd0,    1'b1, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_FREE,  8'd13,  11'd0,    1'b1, STAT_DONE,   10'd0},
    // best fit: exact fit first, then the shortest run that is long enough
    '{POL_BEST,    KIND_ALLOC, 8'd20,  11'd8,    1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd21,  11'd5,    1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd22,  11'd12,   1'b0, STAT_DONE,   10'd0},
    // worst fit, and an owner-zero allocate that leaves the table as it was
    '{POL_WORST,   KIND_ALLOC, 8'd23,  11'd2,    1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd0,   11'd5,    1'b0, STAT_DONE,   10'd0},
    '{KEEP_POLICY, KIND_FREE,  8'd0,   11'd0,    1'b1, STAT_DONE,   10'd0},
    // spare policy code behaves as first fit
    '{POL_SPARE,   KIND_ALLOC, 8'd24,  11'd1,    1'b0, STAT_DONE,   10'd0},
    // oversized request against a fragmented table
    '{POL_FIRST,   KIND_ALLOC, 8'd25,  11'd1024, 1'b1, STAT_NO_FIT, 10'd0},
    '{KEEP_POLICY, KIND_ALLOC, 8'd85,  11'd682,  1'b0, STAT_DONE,   10'd0}
  };

  contiguous_fit_allocator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_owner_id     (in_owner_id),
    .in_request_size (in_request_size),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_unit  (out_start_unit),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_fit_policy  (cfg_fit_policy)
  );

  always #1 clk = ~clk;

  // Apply one request to the shadow table and work out the outcome the block owes.
  // Allocate scans for maximal free runs (one step past the end closes a run that
  // reaches the last unit) and keeps the lowest-addressed run on ties.
  function automatic void apply_request(input logic kind, input logic [OWNER_IN_W-1:0] who,
                                        input logic [SIZE_W-1:0] units,
                                        output logic [STATUS_W-1:0] st,
                                        output logic [START_W-1:0] su);
    owner_t tag;
    int     run_start;
    int     run_len;
    int     pick_start;
    int     pick_len;
    bit     have;
    bit     free_unit;
    bit     take;
    tag        = owner_t'(who);
    st         = STAT_DONE;
    su         = '0;
    have       = 1'b0;
    run_start  = 0;
    run_len    = 0;
    pick_start = 0;
    pick_len   = 0;
    if (kind == KIND_FREE) begin
      for (int u = 0; u < TABLE_UNITS; u++)
        if (unit_owner[u] == tag) unit_owner[u] = '0;
    end else if (units == '0) begin
      st = STAT_ZERO;
    end else begin
      for (int u = 0; u <= TABLE_UNITS; u++) begin
        free_unit = (u < TABLE_UNITS) ? (unit_owner[u] == '0) : 1'b0;
        if (free_unit) begin
          if (run_len == 0) run_start = u;
          run_len++;
        end else if (run_len != 0) begin
          if (run_len >= int'(units)) begin
            case (model_policy)
              POL_BEST:  take = !have || (run_len < pick_len);
              POL_WORST: take = !have || (run_len > pick_len);
              default:   take = !have;
            endcase
            if (take) begin
              have       = 1'b1;
              pick_start = run_start;
              pick_len   = run_len;
            end
          end
          run_len = 0;
        end
      end
      if (!have) begin
        st = STAT_NO_FIT;
      end else begin
        for (int u = pick_start; u < pick_start + int'(units) && u < TABLE_UNITS; u++)
          unit_owner[u] = tag;
        su = START_W'(pick_start);
      end
    end
  endfunction

  // Rising edge: clear the shadow under reset, check any result strobe against the
  // oldest owed outcome, then record config and command transactions in that order.
  always @(posedge clk) begin : track_and_check
    outcome_t want;
    outcome_t owed;
    if (!rst_n) begin
      model_policy = POL_FIRST;
      for (int u = 0; u < TABLE_UNITS; u++) unit_owner[u] = '0;
    end else begin
      // Treat an X strobe as a result too, so it cannot slip by.
      if (out_valid !== 1'b0) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d start %0d",
                   $time, out_status, out_start_unit);
          mismatch_cnt++;
        end else begin
          want = pending_outcomes.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
            mismatch_cnt++;
          end
          if (out_start_unit !== want.start_unit) begin
            $display("%0t: start_unit mismatch, expected %0d, got %0d",
                     $time, want.start_unit, out_start_unit);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        model_policy = cfg_fit_policy;
        policy_writes++;
      end
      if (start && !busy) begin
        apply_request(in_kind, in_owner_id, in_request_size, owed.status, owed.start_unit);
        // Typed-in outcomes override the shadow model; the table still advances.
        if (typed_check) begin
          owed.status     = typed_status;
          owed.start_unit = typed_start;
        end
        pending_outcomes.insert(pending_outcomes.size(), owed);
        items_taken++;
      end
    end
  end

  // Drop start and put junk on the command fields; the block must ignore them.
  task automatic drop_start();
    start           = 1'b0;
    in_kind         = 1'($urandom);
    in_owner_id     = OWNER_IN_W'($urandom);
    in_request_size = SIZE_W'($urandom);
  endtask

  // Hold the sender off for a burst of cycles.
  task automatic pause_sender(input int cycles);
    drop_start();
    repeat (cycles) @(negedge clk);
  endtask

  // Drop start and wait until every owed outcome has come back.
  task automatic quiesce();
    drop_start();
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  // Offer one command and hold it until the block takes the transaction.
  // Start stays high on return so back-to-back items follow without a gap.
  task automatic issue_request(input logic kind, input logic [OWNER_IN_W-1:0] owner,
                               input logic [SIZE_W-1:0] units, input bit typed,
                               input logic [STATUS_W-1:0] st,
                               input logic [START_W-1:0] su);
    int unsigned seen;
    typed_check     = typed;
    typed_status    = st;
    typed_start     = su;
    start           = 1'b1;
    in_kind         = kind;
    in_owner_id     = owner;
    in_request_size = units;
    seen            = items_taken;
    do @(negedge clk); while (items_taken == seen);
  endtask

  // Write the placement rule once the block has gone idle.
  task automatic set_fit_rule(input logic [POLICY_W-1:0] rule);
    int unsigned seen;
    quiesce();
    while (busy) @(negedge clk);
    cfg_valid      = 1'b1;
    cfg_fit_policy = rule;
    seen           = policy_writes;
    do @(negedge clk); while (policy_writes == seen);
    cfg_valid      = 1'b0;
    cfg_fit_policy = POLICY_W'($urandom);
  endtask

  initial begin : stimulus
    logic [POLICY_W-1:0]   phase_rule;
    logic                  kind;
    logic [OWNER_IN_W-1:0] owner;
    logic [SIZE_W-1:0]     units;
    int                    roll;
    bit                    gaps_on;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_ALLOC;
    in_owner_id     = '0;
    in_request_size = '0;
    cfg_valid       = 1'b0;
    cfg_fit_policy  = POL_FIRST;
    typed_check     = 1'b0;
    typed_status    = STAT_DONE;
    typed_start     = '0;
    items_taken     = 0;
    policy_writes   = 0;
    mismatch_cnt    = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed script; the clearing pass after reset shows up as busy on the first row.
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].policy != KEEP_POLICY) set_fit_rule(POLICY_W'(script[r].policy));
      issue_request(script[r].kind, script[r].owner, script[r].units, script[r].typed,
                    script[r].status, script[r].start_unit);
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 17));
    end

    // Random soak in phases, one placement rule per phase. A small owner pool keeps
    // frees hitting live allocations so the table fragments and refills; the last
    // phase runs back to back.
    for (int p = 0; p < SOAK_PHASES; p++) begin
      case (p)
        0:       phase_rule = POL_WORST;
        1:       phase_rule = POL_SPARE;
        2:       phase_rule = POL_BEST;
        3:       phase_rule = POL_FIRST;
        default: phase_rule = POLICY_W'($urandom_range(0, 3));
      endcase
      set_fit_rule(phase_rule);
      gaps_on = (p != SOAK_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        owner = ($urandom_range(0, 9) < 8) ? OWNER_IN_W'($urandom_range(1, 12))
                                           : OWNER_IN_W'($urandom_range(0, 255));
        roll  = $urandom_range(0, 99);
        if (roll < 38) begin
          kind  = KIND_FREE;
          units = SIZE_W'($urandom_range(0, 1024));
        end else begin
          kind = KIND_ALLOC;
          roll = $urandom_range(0, 99);
          if (roll < 3)       units = '0;
          else if (roll < 72) units = SIZE_W'($urandom_range(1, 32));
          else if (roll < 92) units = SIZE_W'($urandom_range(33, 300));
          else                units = SIZE_W'($urandom_range(301, 1024));
        end
        issue_request(kind, owner, units, 1'b0, STAT_DONE, '0);
        if (gaps_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
      end
    end

    // Drain, then watch a full item's worth of cycles for stray strobes.
    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cfa_pkg.sv
rtl/cfa_ram.sv
rtl/contiguous_fit_allocator_unit.sv
tb/contiguous_fit_allocator_unit_tb.sv
